@@ hdl/triangle_edge_function_rasterizer_top_macros.svh @@
// Assertion macros used by the rasterizer top level.
`ifndef TRIANGLE_EDGE_FUNCTION_RASTERIZER_TOP_MACROS_SVH
`define TRIANGLE_EDGE_FUNCTION_RASTERIZER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TEFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rasterizer check failed");

// Consequent must hold in the cycle after the antecedent.
`define TEFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rasterizer check failed");

`endif

@@ hdl/tefr_pkg.sv @@
// Types, constants and codes shared by the rasterizer modules.
`default_nettype none

package tefr_pkg;

    localparam int FRAME_WIDTH_DEF  = 256;
    localparam int FRAME_HEIGHT_DEF = 256;

    localparam int CW   = 12;  // vertex x, y
    localparam int ZW   = 16;  // vertex depth
    localparam int DEPW = 24;  // Q15.8 depth
    localparam int EW   = 13;  // vertex x, y differences
    localparam int EZW  = 17;  // vertex depth differences
    localparam int OW   = 14;  // pixel to vertex offsets
    localparam int MW   = 30;  // partial products of the normal
    localparam int NW   = 31;  // normal components
    localparam int WW   = 28;  // edge function values
    localparam int PW   = 46;  // plane numerator
    localparam int FRAC = 8;
    localparam int NUMW = PW + FRAC;
    localparam int QB   = 26;  // quotient magnitude bits

    localparam logic signed [DEPW-1:0] DEPTH_MAX = 24'sh7FFFFF;
    localparam logic signed [DEPW-1:0] DEPTH_MIN = 24'sh800000;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [7:0]           read_row;
        logic [7:0]           read_col;
        logic signed [ZW-1:0] cz;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cx;
        logic signed [ZW-1:0] bz;
        logic signed [CW-1:0] by_coord;
        logic signed [CW-1:0] bx;
        logic signed [ZW-1:0] az;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] ax;
    } t_in_item;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ,
        ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6,
        ST_PIXEL, ST_DIV, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        STG_NONE, STG_1, STG_2, STG_3, STG_4, STG_5, STG_6
    } t_stage;

    typedef enum logic [1:0] {
        RES_NONE, RES_ZERO, RES_REJ, RES_READ
    } t_res;

    typedef struct packed {
        logic   capture;
        logic   clr_init;
        logic   clr_step;
        t_stage stage;
        logic   div_start;
        logic   pix_step;
        logic   pix_write;
        logic   res_load;
        t_res   res;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic nz_zero;
        logic box_empty;
        logic in_tri;
        logic last_pix;
        logic div_done;
    } t_stat;

endpackage

`default_nettype wire

@@ hdl/tefr_div.sv @@
// Sequential restoring divider with truncation toward zero and Q15.8 saturation.
`default_nettype none

module tefr_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [tefr_pkg::NUMW-1:0]     i_num,
    input  logic signed [tefr_pkg::NW-1:0]       i_den,
    output logic                                 o_done,
    output logic signed [tefr_pkg::DEPW-1:0]     o_quot
);

    localparam int NUMW = tefr_pkg::NUMW;
    localparam int NW   = tefr_pkg::NW;
    localparam int QB   = tefr_pkg::QB;
    localparam int DEPW = tefr_pkg::DEPW;
    localparam int SW   = NW + QB;
    localparam int CNTW = $clog2(QB + 1);
    localparam logic [QB-1:0] MAG_POS = QB'(2 ** (DEPW - 1) - 1);
    localparam logic [QB-1:0] MAG_NEG = QB'(2 ** (DEPW - 1));

    logic [NUMW-1:0] r_rem;
    logic [SW-1:0]   r_dsh;
    logic [QB-1:0]   r_q;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_fin;
    logic            r_done;
    logic            r_ovf;
    logic            r_neg;
    logic signed [DEPW-1:0] r_quot;

    logic [NUMW-1:0] num_abs;
    logic [NW-1:0]   den_abs;
    logic            ge;
    logic [NUMW-1:0] diff;
    logic [QB-1:0]   q_neg;
    logic signed [DEPW-1:0] sat;

    always_comb begin
        num_abs = i_num[NUMW-1] ? NUMW'(-i_num) : NUMW'(i_num);
        den_abs = i_den[NW-1] ? NW'(-i_den) : NW'(i_den);
        ge      = SW'(r_rem) >= r_dsh;
        diff    = r_rem - NUMW'(r_dsh);
        q_neg   = ~r_q + QB'(1);
        if (r_neg) begin
            sat = (r_ovf || r_q > MAG_NEG) ? tefr_pkg::DEPTH_MIN : q_neg[DEPW-1:0];
        end else begin
            sat = (r_ovf || r_q > MAG_POS) ? tefr_pkg::DEPTH_MAX : r_q[DEPW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // The first step only tests whether the quotient overflows its magnitude bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= num_abs;
            r_dsh <= {den_abs, QB'(0)};
            r_q   <= '0;
            r_ovf <= 1'b0;
            r_neg <= i_num[NUMW-1] ^ i_den[NW-1];
        end else if (r_busy) begin
            r_dsh <= r_dsh >> 1;
            if (r_cnt == CNTW'(QB)) begin
                r_ovf <= ge;
            end else begin
                if (ge) begin
                    r_rem <= diff;
                end
                r_q <= {r_q[QB-2:0], ge};
            end
        end
        if (r_fin) begin
            r_quot <= sat;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ hdl/tefr_dp.sv @@
// Rasterizer datapath: triangle setup, edge walk, frame stores and result register.
`default_nettype none

module tefr_dp #(
    parameter int P_W = tefr_pkg::FRAME_WIDTH_DEF,
    parameter int P_H = tefr_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tefr_pkg::t_in_item               i_in,
    input  tefr_pkg::t_cmd                   i_cmd,
    output tefr_pkg::t_stat                  o_stat,
    output logic                             o_covered,
    output logic signed [tefr_pkg::DEPW-1:0] o_depth,
    output logic                             o_rejected
);

    localparam int CW   = tefr_pkg::CW;
    localparam int EW   = tefr_pkg::EW;
    localparam int EZW  = tefr_pkg::EZW;
    localparam int OW   = tefr_pkg::OW;
    localparam int MW   = tefr_pkg::MW;
    localparam int NW   = tefr_pkg::NW;
    localparam int WW   = tefr_pkg::WW;
    localparam int PW   = tefr_pkg::PW;
    localparam int DEPW = tefr_pkg::DEPW;
    localparam int NUMW = tefr_pkg::NUMW;
    localparam int FRAC = tefr_pkg::FRAC;
    localparam int XW   = $clog2(P_W);
    localparam int YW   = $clog2(P_H);
    localparam int NPIX = P_W * P_H;
    localparam int AW   = $clog2(NPIX);
    localparam logic signed [EW-1:0] XMAX = EW'(P_W - 1);
    localparam logic signed [EW-1:0] YMAX = EW'(P_H - 1);

    tefr_pkg::t_in_item r_in;

    logic               r_cov_mem [NPIX];
    logic [DEPW-1:0]    r_dep_mem [NPIX];
    logic               r_cov_q;
    logic [DEPW-1:0]    r_dep_q;
    logic [AW-1:0]      r_clr_addr;

    logic signed [EW-1:0]  r_e1x, r_e1y, r_e2x, r_e2y;
    logic signed [EZW-1:0] r_e1z, r_e2z;
    logic signed [EW-1:0]  r_ex [3];
    logic signed [EW-1:0]  r_ey [3];
    logic signed [OW-1:0]  r_ox [3];
    logic signed [OW-1:0]  r_oy [3];
    logic signed [WW-1:0]  r_ea [3];
    logic signed [WW-1:0]  r_eb [3];
    logic signed [WW-1:0]  r_w  [3];
    logic signed [WW-1:0]  r_wr [3];
    logic signed [MW-1:0]  r_m0, r_m1, r_m2, r_m3, r_m4, r_m5;
    logic signed [NW-1:0]  r_nx, r_ny, r_nz;
    logic signed [PW-1:0]  r_t0, r_t1, r_t2, r_t3, r_t4;
    logic signed [PW-1:0]  r_d, r_p, r_prow;
    logic [XW-1:0]         r_x0, r_x1, r_x;
    logic [YW-1:0]         r_y0, r_y1, r_y;
    logic                  r_empty;

    logic                  r_covered;
    logic signed [DEPW-1:0] r_depth;
    logic                  r_rejected;

    logic signed [CW-1:0]  px [3];
    logic signed [CW-1:0]  py [3];
    logic signed [CW-1:0]  qx [3];
    logic signed [CW-1:0]  qy [3];
    logic signed [CW-1:0]  minx, maxx, miny, maxy;
    logic signed [EW-1:0]  lx, hx, ly, hy;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         pix_addr;
    logic                  in_frame;
    logic                  last_x;
    logic [2:0]            neg_w;
    logic signed [NUMW-1:0] num;
    logic                  div_done;
    logic signed [DEPW-1:0] div_q;

    // Edge k runs from p to q: edge 0 is B to C, edge 1 is C to A, edge 2 is A to B.
    always_comb begin
        px[0] = r_in.bx;       py[0] = r_in.by_coord;
        qx[0] = r_in.cx;       qy[0] = r_in.cy;
        px[1] = r_in.cx;       py[1] = r_in.cy;
        qx[1] = r_in.ax;       qy[1] = r_in.ay;
        px[2] = r_in.ax;       py[2] = r_in.ay;
        qx[2] = r_in.bx;       qy[2] = r_in.by_coord;

        minx = r_in.ax;
        maxx = r_in.ax;
        miny = r_in.ay;
        maxy = r_in.ay;
        if (r_in.bx < minx) minx = r_in.bx;
        if (r_in.cx < minx) minx = r_in.cx;
        if (r_in.bx > maxx) maxx = r_in.bx;
        if (r_in.cx > maxx) maxx = r_in.cx;
        if (r_in.by_coord < miny) miny = r_in.by_coord;
        if (r_in.cy < miny) miny = r_in.cy;
        if (r_in.by_coord > maxy) maxy = r_in.by_coord;
        if (r_in.cy > maxy) maxy = r_in.cy;

        lx = minx[CW-1] ? '0 : EW'(minx);
        ly = miny[CW-1] ? '0 : EW'(miny);
        hx = (EW'(maxx) > XMAX) ? XMAX : EW'(maxx);
        hy = (EW'(maxy) > YMAX) ? YMAX : EW'(maxy);

        rd_addr  = AW'(32'(r_in.read_row) * P_W + 32'(r_in.read_col));
        in_frame = (32'(r_in.read_col) < P_W) && (32'(r_in.read_row) < P_H);
        pix_addr = AW'(32'(r_y) * P_W + 32'(r_x));
        last_x   = (r_x == r_x1);
        for (int k = 0; k < 3; k++) begin
            neg_w[k] = r_w[k][WW-1] || (r_w[k] == '0);
        end
        num = $signed({r_p, FRAC'(0)});
    end

    // Frame stores.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_cov_mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.pix_write) begin
            r_cov_mem[pix_addr] <= 1'b1;
        end
        if (i_cmd.pix_write) begin
            r_dep_mem[pix_addr] <= div_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cov_q <= r_cov_mem[rd_addr];
        r_dep_q <= r_dep_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_init) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Setup runs in six steps, each with at most one product per term.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in;
        end
        case (i_cmd.stage)
            tefr_pkg::STG_1: begin
                r_e1x <= EW'(r_in.bx) - EW'(r_in.ax);
                r_e1y <= EW'(r_in.by_coord) - EW'(r_in.ay);
                r_e1z <= EZW'(r_in.bz) - EZW'(r_in.az);
                r_e2x <= EW'(r_in.cx) - EW'(r_in.ax);
                r_e2y <= EW'(r_in.cy) - EW'(r_in.ay);
                r_e2z <= EZW'(r_in.cz) - EZW'(r_in.az);
                for (int k = 0; k < 3; k++) begin
                    r_ex[k] <= EW'(qx[k]) - EW'(px[k]);
                    r_ey[k] <= EW'(qy[k]) - EW'(py[k]);
                end
                r_x0    <= XW'(lx);
                r_x1    <= XW'(hx);
                r_y0    <= YW'(ly);
                r_y1    <= YW'(hy);
                r_empty <= (hx < lx) || (hy < ly);
            end
            tefr_pkg::STG_2: begin
                r_m0 <= MW'(r_e1y) * MW'(r_e2z);
                r_m1 <= MW'(r_e1z) * MW'(r_e2y);
                r_m2 <= MW'(r_e1z) * MW'(r_e2x);
                r_m3 <= MW'(r_e1x) * MW'(r_e2z);
                r_m4 <= MW'(r_e1x) * MW'(r_e2y);
                r_m5 <= MW'(r_e1y) * MW'(r_e2x);
                for (int k = 0; k < 3; k++) begin
                    r_ox[k] <= OW'($signed({1'b0, r_x0})) - OW'(px[k]);
                    r_oy[k] <= OW'($signed({1'b0, r_y0})) - OW'(py[k]);
                end
            end
            tefr_pkg::STG_3: begin
                r_nx <= NW'(r_m0) - NW'(r_m1);
                r_ny <= NW'(r_m2) - NW'(r_m3);
                r_nz <= NW'(r_m4) - NW'(r_m5);
                for (int k = 0; k < 3; k++) begin
                    r_ea[k] <= WW'(r_ex[k]) * WW'(r_oy[k]);
                    r_eb[k] <= WW'(r_ey[k]) * WW'(r_ox[k]);
                end
            end
            tefr_pkg::STG_4: begin
                r_t0 <= PW'(r_in.ax) * PW'(r_nx);
                r_t1 <= PW'(r_in.ay) * PW'(r_ny);
                r_t2 <= PW'(r_in.az) * PW'(r_nz);
                r_t3 <= PW'(r_nx) * PW'($signed({1'b0, r_x0}));
                r_t4 <= PW'(r_ny) * PW'($signed({1'b0, r_y0}));
                for (int k = 0; k < 3; k++) begin
                    r_w[k]  <= r_ea[k] - r_eb[k];
                    r_wr[k] <= r_ea[k] - r_eb[k];
                end
            end
            tefr_pkg::STG_5: begin
                r_d <= r_t0 + r_t1 + r_t2;
            end
            tefr_pkg::STG_6: begin
                r_p    <= r_d - r_t3 - r_t4;
                r_prow <= r_d - r_t3 - r_t4;
                r_x    <= r_x0;
                r_y    <= r_y0;
            end
            default: begin
            end
        endcase

        // Edge values and plane numerator move by constant steps per pixel.
        if (i_cmd.pix_step) begin
            if (last_x) begin
                r_x    <= r_x0;
                r_y    <= r_y + YW'(1);
                r_prow <= r_prow - PW'(r_ny);
                r_p    <= r_prow - PW'(r_ny);
                for (int k = 0; k < 3; k++) begin
                    r_wr[k] <= r_wr[k] + WW'(r_ex[k]);
                    r_w[k]  <= r_wr[k] + WW'(r_ex[k]);
                end
            end else begin
                r_x <= r_x + XW'(1);
                r_p <= r_p - PW'(r_nx);
                for (int k = 0; k < 3; k++) begin
                    r_w[k] <= r_w[k] - WW'(r_ey[k]);
                end
            end
        end

        if (i_cmd.res_load) begin
            case (i_cmd.res)
                tefr_pkg::RES_READ: begin
                    r_covered  <= in_frame && r_cov_q;
                    r_depth    <= (in_frame && r_cov_q) ? $signed(r_dep_q) : '0;
                    r_rejected <= 1'b0;
                end
                tefr_pkg::RES_REJ: begin
                    r_covered  <= 1'b0;
                    r_depth    <= '0;
                    r_rejected <= 1'b1;
                end
                default: begin
                    r_covered  <= 1'b0;
                    r_depth    <= '0;
                    r_rejected <= 1'b0;
                end
            endcase
        end
    end

    tefr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num),
        .i_den   (r_nz),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_comb begin
        o_stat.clr_last  = (r_clr_addr == AW'(NPIX - 1));
        o_stat.nz_zero   = (r_nz == '0);
        o_stat.box_empty = r_empty;
        o_stat.in_tri    = &neg_w;
        o_stat.last_pix  = last_x && (r_y == r_y1);
        o_stat.div_done  = div_done;
    end

    assign o_covered  = r_covered;
    assign o_depth    = r_depth;
    assign o_rejected = r_rejected;

endmodule

`default_nettype wire

@@ hdl/tefr_ctrl.sv @@
// Rasterizer controller: sequences clear, read and draw requests and unused opcodes.
`default_nettype none

module tefr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tefr_pkg::t_op     i_op,
    input  logic              i_out_ready,
    input  tefr_pkg::t_stat   i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output tefr_pkg::t_cmd    o_cmd
);

    tefr_pkg::t_state r_state, n_state;
    tefr_pkg::t_res   r_res, n_res;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tefr_pkg::ST_CLEAR;
            r_res       <= tefr_pkg::RES_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.stage = tefr_pkg::STG_NONE;
        o_cmd.res   = r_res;
        o_in_ready  = 1'b0;
        case (r_state)
            tefr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_op)
                        tefr_pkg::OP_CLEAR: begin
                            o_cmd.clr_init = 1'b1;
                            n_res          = tefr_pkg::RES_ZERO;
                            n_state        = tefr_pkg::ST_CLEAR;
                        end
                        tefr_pkg::OP_DRAW: begin
                            n_res   = tefr_pkg::RES_ZERO;
                            n_state = tefr_pkg::ST_S1;
                        end
                        tefr_pkg::OP_READ: begin
                            n_res   = tefr_pkg::RES_READ;
                            n_state = tefr_pkg::ST_READ;
                        end
                        default: begin
                            n_res   = tefr_pkg::RES_ZERO;
                            n_state = tefr_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            tefr_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = tefr_pkg::ST_DONE;
                end
            end
            tefr_pkg::ST_READ: begin
                n_state = tefr_pkg::ST_DONE;
            end
            tefr_pkg::ST_S1: begin
                o_cmd.stage = tefr_pkg::STG_1;
                n_state     = tefr_pkg::ST_S2;
            end
            tefr_pkg::ST_S2: begin
                o_cmd.stage = tefr_pkg::STG_2;
                n_state     = tefr_pkg::ST_S3;
            end
            tefr_pkg::ST_S3: begin
                o_cmd.stage = tefr_pkg::STG_3;
                n_state     = tefr_pkg::ST_S4;
            end
            tefr_pkg::ST_S4: begin
                o_cmd.stage = tefr_pkg::STG_4;
                // A flat triangle is rejected even when its box misses the frame.
                if (i_stat.nz_zero) begin
                    n_res   = tefr_pkg::RES_REJ;
                    n_state = tefr_pkg::ST_DONE;
                end else if (i_stat.box_empty) begin
                    n_state = tefr_pkg::ST_DONE;
                end else begin
                    n_state = tefr_pkg::ST_S5;
                end
            end
            tefr_pkg::ST_S5: begin
                o_cmd.stage = tefr_pkg::STG_5;
                n_state     = tefr_pkg::ST_S6;
            end
            tefr_pkg::ST_S6: begin
                o_cmd.stage = tefr_pkg::STG_6;
                n_state     = tefr_pkg::ST_PIXEL;
            end
            tefr_pkg::ST_PIXEL: begin
                if (i_stat.in_tri) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = tefr_pkg::ST_DIV;
                end else if (i_stat.last_pix) begin
                    n_state = tefr_pkg::ST_DONE;
                end else begin
                    o_cmd.pix_step = 1'b1;
                end
            end
            tefr_pkg::ST_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.pix_write = 1'b1;
                    if (i_stat.last_pix) begin
                        n_state = tefr_pkg::ST_DONE;
                    end else begin
                        o_cmd.pix_step = 1'b1;
                        n_state        = tefr_pkg::ST_PIXEL;
                    end
                end
            end
            tefr_pkg::ST_DONE: begin
                // The clearing pass after reset ends here without an answer.
                if (r_res == tefr_pkg::RES_NONE) begin
                    n_state = tefr_pkg::ST_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = tefr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tefr_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ hdl/triangle_edge_function_rasterizer_top.sv @@
// Top level of the half-space triangle rasterizer with coverage and depth stores.
//
//  Channel   Direction  Handshake              Payload
//  s_axis    in         tvalid / tready        tuser op, tdata vertices and read pixel
//  m_axis    out        tvalid / tready        tdata covered, depth, rejected
//
// Requests are handled one at a time; a finished result waits in the output register
// while the next request is taken. A read passes through the READ and DONE states, an
// unused opcode only through DONE. A clear sweeps the coverage store one pixel a cycle.
// A draw runs the setup states S1 to S6 (a flat or off-frame one stops after S4), then
// walks the clipped box pixel by pixel, waiting at each covered pixel for the bit-serial
// depth divider, and ends in DONE. After reset the same coverage sweep runs before
// s_axis_tready rises; a stalled m_axis holds its result and delays only the next one.
`default_nettype none

`include "triangle_edge_function_rasterizer_top_macros.svh"

module triangle_edge_function_rasterizer_top #(
    parameter int FRAME_WIDTH  = tefr_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = tefr_pkg::FRAME_HEIGHT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz, read_col, read_row
    input  logic [135:0] s_axis_tdata,
    // op
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // covered, pixel_depth, rejected, zero fill
    output logic [31:0]  m_axis_tdata
);

    tefr_pkg::t_cmd  w_cmd;
    tefr_pkg::t_stat w_stat;
    logic            w_covered;
    logic            w_rejected;
    logic signed [tefr_pkg::DEPW-1:0] w_depth;

    tefr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_op        (tefr_pkg::t_op'(s_axis_tuser)),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    tefr_dp #(
        .P_W (FRAME_WIDTH),
        .P_H (FRAME_HEIGHT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tefr_pkg::t_in_item'(s_axis_tdata)),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_covered  (w_covered),
        .o_depth    (w_depth),
        .o_rejected (w_rejected)
    );

    assign m_axis_tdata = {6'b0, w_rejected, w_depth, w_covered};

    `TEFR_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `TEFR_ASSERT_NOW(a_load_slot_free, i_clk, i_rst_n, w_cmd.res_load, !m_axis_tvalid || m_axis_tready)
    `TEFR_ASSERT_NOW(a_write_in_tri, i_clk, i_rst_n, w_cmd.pix_write, w_stat.in_tri && w_stat.div_done)

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Stream testbench for the half-space triangle rasterizer with coverage and depth stores.
`timescale 1ns / 100ps

module testbench;

    localparam int FW = 256;
    localparam int FH = 256;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        tefr_pkg::t_op      op;
        tefr_pkg::t_in_item data;
    } t_raster_req;

    typedef struct {
        logic                 covered;
        logic signed [23:0]   depth;
        logic                 rejected;
    } t_pixel_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz, read_col, read_row
    logic [135:0] s_axis_tdata = '0;
    // op
    logic [1:0]   s_axis_tuser = tefr_pkg::OP_NONE;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // covered, pixel_depth, rejected, zero fill
    logic [31:0]  m_axis_tdata;

    t_raster_req  pending_reqs[$];
    t_pixel_res   expected_results[$];
    bit           cov_frame[FW*FH];
    logic [23:0]  depth_frame[FW*FH];
    int           n_total, n_sent, n_results, n_errors, n_draws, n_reads, n_rejects;
    int           idle_cycles;
    logic         req_taken = 1'b0;
    int           last_x = 10, last_y = 10;

    triangle_edge_function_rasterizer_top DUT (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    always #10 i_clk = ~i_clk;

    // Computes the answer to one request and updates the frame copy.
    function automatic t_pixel_res rasterize(input tefr_pkg::t_op op,
                                             input tefr_pkg::t_in_item it);
        t_pixel_res r;
        longint ax, ay, az, bx, by, bz, cx, cy, cz;
        longint nx, ny, nz, pd, x0, x1, y0, y1, w0, w1, w2, z;
        int idx;
        r.covered = 1'b0;
        r.depth = '0;
        r.rejected = 1'b0;
        case (op)
            tefr_pkg::OP_CLEAR: begin
                foreach (cov_frame[i]) cov_frame[i] = 1'b0;
            end
            tefr_pkg::OP_READ: begin
                idx = int'(it.read_row) * FW + int'(it.read_col);
                if (cov_frame[idx]) begin
                    r.covered = 1'b1;
                    r.depth = depth_frame[idx];
                end
            end
            tefr_pkg::OP_DRAW: begin
                ax = it.ax; ay = it.ay; az = it.az;
                bx = it.bx; by = it.by_coord; bz = it.bz;
                cx = it.cx; cy = it.cy; cz = it.cz;
                nx = (by - ay) * (cz - az) - (bz - az) * (cy - ay);
                ny = (bz - az) * (cx - ax) - (bx - ax) * (cz - az);
                nz = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
                if (nz == 0) begin
                    r.rejected = 1'b1;
                end else begin
                    pd = ax * nx + ay * ny + az * nz;
                    x0 = ax < bx ? ax : bx; x0 = cx < x0 ? cx : x0;
                    x1 = ax > bx ? ax : bx; x1 = cx > x1 ? cx : x1;
                    y0 = ay < by ? ay : by; y0 = cy < y0 ? cy : y0;
                    y1 = ay > by ? ay : by; y1 = cy > y1 ? cy : y1;
                    if (x0 < 0) x0 = 0;
                    if (y0 < 0) y0 = 0;
                    if (x1 > FW - 1) x1 = FW - 1;
                    if (y1 > FH - 1) y1 = FH - 1;
                    for (longint y = y0; y <= y1; y++) begin
                        for (longint x = x0; x <= x1; x++) begin
                            w0 = (cx - bx) * (y - by) - (cy - by) * (x - bx);
                            w1 = (ax - cx) * (y - cy) - (ay - cy) * (x - cx);
                            w2 = (bx - ax) * (y - ay) - (by - ay) * (x - ax);
                            if (w0 <= 0 && w1 <= 0 && w2 <= 0) begin
                                // Signed division truncates toward zero.
                                z = ((pd - nx * x - ny * y) * 256) / nz;
                                if (z > 8388607) z = 8388607;
                                if (z < -8388608) z = -8388608;
                                idx = int'(y) * FW + int'(x);
                                cov_frame[idx] = 1'b1;
                                depth_frame[idx] = z[23:0];
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic tefr_pkg::t_in_item rand_item();
        logic [159:0] b;
        b = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return tefr_pkg::t_in_item'(b[135:0]);
    endfunction

    function automatic tefr_pkg::t_in_item make_tri(input int x0, y0, x1, y1, x2, y2);
        tefr_pkg::t_in_item t;
        t = '0;
        t.ax = 12'(x0); t.ay = 12'(y0); t.az = 16'($urandom);
        t.bx = 12'(x1); t.by_coord = 12'(y1); t.bz = 16'($urandom);
        t.cx = 12'(x2); t.cy = 12'(y2); t.cz = 16'($urandom);
        t.read_col = 8'($urandom);
        t.read_row = 8'($urandom);
        return t;
    endfunction

    task automatic add_req(input tefr_pkg::t_op op, input tefr_pkg::t_in_item t);
        t_raster_req q;
        q.op = op;
        q.data = t;
        pending_reqs.push_back(q);
    endtask

    task automatic add_read(input int col, input int row);
        tefr_pkg::t_in_item t;
        t = rand_item();
        t.read_col = 8'(col);
        t.read_row = 8'(row);
        add_req(tefr_pkg::OP_READ, t);
    endtask

    // Small triangle with random winding somewhere around the frame, edges included.
    task automatic add_small_tri();
        int bx0, by0, sz;
        bx0 = int'($urandom_range(0, FW + 8)) - 6;
        by0 = int'($urandom_range(0, FH + 8)) - 6;
        sz = $urandom_range(1, 11);
        last_x = bx0 < 0 ? 0 : (bx0 > FW - 1 ? FW - 1 : bx0);
        last_y = by0 < 0 ? 0 : (by0 > FH - 1 ? FH - 1 : by0);
        add_req(tefr_pkg::OP_DRAW,
                make_tri(bx0 + $urandom_range(0, sz), by0 + $urandom_range(0, sz),
                         bx0 + $urandom_range(0, sz), by0 + $urandom_range(0, sz),
                         bx0 + $urandom_range(0, sz), by0 + $urandom_range(0, sz)));
    endtask

    initial begin
        tefr_pkg::t_in_item t;
        int kind, lo, hi, xa, xb, xc;
        // Directed part.
        add_read(0, 0);
        add_read(255, 255);
        t = '0;
        add_req(tefr_pkg::OP_NONE, ~t);
        add_req(tefr_pkg::OP_DRAW, make_tri(10, 10, 20, 10, 10, 20));
        add_req(tefr_pkg::OP_DRAW, make_tri(30, 10, 30, 20, 40, 10));
        add_read(12, 12);
        add_read(31, 11);
        // Clipped at the frame corner, then at the far corner with extreme depths.
        add_req(tefr_pkg::OP_DRAW, make_tri(-5, -5, -5, 6, 6, -5));
        t = make_tri(250, 250, 262, 262, 262, 250);
        t.az = 16'sh7FFF; t.bz = 16'sh8000; t.cz = 16'sh7FFF;
        add_req(tefr_pkg::OP_DRAW, t);
        t = make_tri(0, 0, 1, 0, 0, 1);
        t.az = 16'sh8000; t.bz = 16'sh7FFF; t.cz = 16'sh7FFF;
        add_req(tefr_pkg::OP_DRAW, t);
        add_read(0, 0);
        add_read(1, 1);
        add_read(255, 255);
        add_read(255, 250);
        // Degenerate triangles, one spanning the extremes of the coordinates.
        add_req(tefr_pkg::OP_DRAW, make_tri(-2048, -2048, 2047, 2047, 0, 0));
        add_req(tefr_pkg::OP_DRAW, make_tri(5, 5, 5, 5, 5, 5));
        // Boxes wholly off the frame.
        add_req(tefr_pkg::OP_DRAW, make_tri(2047, 2047, 2040, 2047, 2047, 2040));
        add_req(tefr_pkg::OP_DRAW, make_tri(-2048, -2048, -2048, -2000, -2000, -2048));
        add_req(tefr_pkg::OP_DRAW, make_tri(300, 5, 310, 5, 300, 15));
        add_req(tefr_pkg::OP_CLEAR, t);
        add_read(12, 12);
        add_read(0, 0);
        // Random part.
        for (int i = 0; i < 560; i++) begin
            kind = $urandom_range(0, 99);
            if (i == 250 || i == 480) begin
                add_req(tefr_pkg::OP_CLEAR, make_tri(0, 0, 0, 0, 0, 0));
            end else if (kind < 38) begin
                add_small_tri();
            end else if (kind < 72) begin
                add_read(last_x + $urandom_range(0, 10) > FW - 1 ? FW - 1
                         : last_x + $urandom_range(0, 10),
                         last_y + $urandom_range(0, 10) > FH - 1 ? FH - 1
                         : last_y + $urandom_range(0, 10));
            end else if (kind < 84) begin
                add_read($urandom_range(0, FW - 1), $urandom_range(0, FH - 1));
            end else if (kind < 92) begin
                // All x on one side of the frame, y anywhere.
                if ($urandom_range(0, 1)) begin lo = FW; hi = 2047; end
                else begin lo = -2048; hi = -1; end
                xa = $urandom_range(0, hi - lo) + lo;
                xb = $urandom_range(0, hi - lo) + lo;
                xc = $urandom_range(0, hi - lo) + lo;
                t = make_tri(xa, 0, xb, 0, xc, 0);
                t.ay = 12'($urandom); t.by_coord = 12'($urandom); t.cy = 12'($urandom);
                add_req(tefr_pkg::OP_DRAW, t);
            end else if (kind < 97) begin
                t = make_tri(0, 0, 0, 0, 0, 0);
                t.ax = 12'($urandom); t.ay = 12'($urandom);
                t.bx = 12'($urandom); t.by_coord = 12'($urandom);
                t.cx = t.bx; t.cy = t.by_coord;
                add_req(tefr_pkg::OP_DRAW, t);
            end else begin
                add_req(tefr_pkg::OP_NONE, rand_item());
            end
        end
        n_total = pending_reqs.size();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (n_sent == n_total && expected_results.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d requests: %0d draws (%0d rejected), %0d reads, %0d results.",
                 n_sent, n_draws, n_rejects, n_reads, n_results);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("[triangle_edge_function_rasterizer_top] OK");
        end else begin
            $display("[triangle_edge_function_rasterizer_top] ERROR");
        end
        $finish;
    end

    // Driver: inputs change on the falling edge.
    always @(negedge i_clk) begin
        int phase, s_idle, r_stall;
        t_raster_req q;
        phase = n_total > 0 ? (n_sent * 4) / n_total : 0;
        s_idle = (phase == 1) ? 46 : (phase == 3) ? 17 : 0;
        r_stall = (phase == 2) ? 46 : (phase == 3) ? 17 : 0;
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(0, 99) >= r_stall);
            if (!s_axis_tvalid || req_taken) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= s_idle) begin
                    q = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= q.data;
                    s_axis_tuser <= q.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: handshakes are sampled on the rising edge.
    always @(posedge i_clk) begin
        t_pixel_res e;
        req_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                e = rasterize(tefr_pkg::t_op'(s_axis_tuser),
                              tefr_pkg::t_in_item'(s_axis_tdata));
                expected_results.push_back(e);
                n_sent++;
                if (s_axis_tuser == tefr_pkg::OP_DRAW) n_draws++;
                if (s_axis_tuser == tefr_pkg::OP_READ) n_reads++;
                if (e.rejected) n_rejects++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: %h", m_axis_tdata);
                    n_errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_axis_tdata[0] !== e.covered) begin
                        $error("covered: expected %0d, got %0d", e.covered, m_axis_tdata[0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[24:1] !== e.depth) begin
                        $error("pixel_depth: expected %0d, got %0d", e.depth,
                               $signed(m_axis_tdata[24:1]));
                        n_errors++;
                    end
                    if (m_axis_tdata[25] !== e.rejected) begin
                        $error("rejected: expected %0d, got %0d", e.rejected,
                               m_axis_tdata[25]);
                        n_errors++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[triangle_edge_function_rasterizer_top] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/tefr_pkg.sv
hdl/tefr_div.sv
hdl/tefr_dp.sv
hdl/tefr_ctrl.sv
hdl/triangle_edge_function_rasterizer_top.sv
tb/sv/testbench.sv
